// File: hw/rtl/lpcv_pkg.sv
// shared types and constants of the prefer-clean lru victim selector
package lpcv_pkg;

    localparam int KIND_W   = 2;
    localparam int SET_IN_W = 6;
    localparam int WAY_IN_W = 2;
    localparam int TAG_IN_W = 20;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // item kinds as seen on the input channel
    localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VICTIM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECORD = 2'd2;

    // operations after classification
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_ACCESS = 2'd1;
    localparam logic [1:0] OP_VICTIM = 2'd2;
    localparam logic [1:0] OP_RECORD = 2'd3;

    // register indexes, taken from paddr[2]
    localparam logic REG_PREFER_CLEAN = 1'b0;
    localparam logic REG_WAYS_IN_USE  = 1'b1;

    localparam logic [2:0] WAYS_IN_USE_RESET = 3'd4;

    typedef struct packed {
        logic [1:0]          op;
        logic [SET_IN_W-1:0] set_index;
        logic [WAY_IN_W-1:0] way_index;
        logic [TAG_IN_W-1:0] tag;
        logic                modified;
    } t_cmd;

    typedef struct packed {
        logic       prefer_clean;
        logic [2:0] ways_in_use;
    } t_cfg;

    typedef struct packed {
        logic [WAY_IN_W-1:0] victim_way;
        logic                victim_valid;
    } t_res;

endpackage

// File: hw/rtl/lpcv_ram.sv
// generic single-write, single-read ram with registered read data
module lpcv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/lpcv_front.sv
// front end: accepts items, classifies them and queues the commands
module lpcv_front
    import lpcv_pkg::*;
#(
    parameter int WAYS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SET_IN_W-1:0] i_set_index,
    input  logic [WAY_IN_W-1:0] i_way_index,
    input  logic [TAG_IN_W-1:0] i_tag,
    input  logic                i_modified,
    input  logic                i_open,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd,
    input  logic                i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    always_comb begin
        w_cmd.set_index = i_set_index;
        w_cmd.way_index = i_way_index;
        w_cmd.tag       = i_tag;
        w_cmd.modified  = i_modified;
        unique case (i_kind)
            KIND_ACCESS: w_cmd.op = OP_ACCESS;
            KIND_VICTIM: w_cmd.op = OP_VICTIM;
            // a record to a way beyond the array becomes a no-op
            KIND_RECORD: w_cmd.op = (32'(i_way_index) < WAYS) ? OP_RECORD : OP_NONE;
            default:     w_cmd.op = OP_NONE;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2) || !i_open;
    assign w_push      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// File: hw/rtl/lpcv_back.sv
// back end: read-modify-write of one set row per command, result queue
module lpcv_back
    import lpcv_pkg::*;
#(
    parameter int SETS     = 64,
    parameter int WAYS     = 4,
    parameter int TAG_BITS = 20,
    parameter int AGE_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    output logic o_open,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_empty,
    output t_res o_res,
    input  logic i_pop
);

    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LVL     = $clog2(WAYS);
    localparam int PAD     = 1 << LVL;
    localparam int LINE_W  = AGE_BITS + TAG_BITS + 1;
    localparam int ROW_W   = WAYS * LINE_W;
    localparam int TAG_LSB = 1;
    localparam int AGE_LSB = 1 + TAG_BITS;
    localparam int SET_TBL = 1 << SET_IN_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [SET_W-1:0] r_clr, n_clr;
    logic [SET_W-1:0] r_set;
    t_cmd             r_cmd;

    logic [SET_W-1:0] w_set_tbl [SET_TBL];
    logic [SET_W-1:0] w_raddr, w_waddr;
    logic [ROW_W-1:0] w_row, w_wdata, w_new_row;
    logic             w_we, w_take, w_exec;

    logic [TAG_BITS-1:0] w_tag;
    logic [2:0]          w_n;
    logic [WAYS-1:0]     w_use;
    logic [AGE_BITS-1:0] w_age;
    logic                w_tree_v [2][PAD];
    logic [AGE_BITS-1:0] w_tree_a [2][PAD];
    logic [WAY_W-1:0]    w_tree_i [2][PAD];
    logic [WAY_W-1:0]    w_victim;
    t_res                w_res;

    t_res       r_oq [2];
    logic       r_owp, r_orp;
    logic [1:0] r_ocnt;
    logic       w_opop;

    // set index reduced modulo the set count
    for (genvar g = 0; g < SET_TBL; g++) begin : g_set_tbl
        assign w_set_tbl[g] = SET_W'(g % SETS);
    end

    lpcv_ram #(
        .WIDTH(ROW_W),
        .DEPTH(SETS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_row)
    );

    assign o_open    = (r_state != ST_CLEAR);
    assign w_take    = (r_state == ST_IDLE) && i_cmd_valid && (r_ocnt != 2'd2);
    assign w_exec    = (r_state == ST_EXEC);
    assign o_cmd_pop = w_take;
    assign w_raddr   = w_set_tbl[i_cmd.set_index];
    assign w_we      = (r_state == ST_CLEAR) || w_exec;
    assign w_waddr   = (r_state == ST_CLEAR) ? r_clr : r_set;
    assign w_wdata   = (r_state == ST_CLEAR) ? '0 : w_new_row;
    assign w_tag     = TAG_BITS'(r_cmd.tag);

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == SET_W'(SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_take) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= i_cmd;
            r_set <= w_raddr;
        end
    end

    // active ways: zero counts as one, clamped to the array
    always_comb begin
        w_n = (i_cfg.ways_in_use == 3'd0) ? 3'd1 : i_cfg.ways_in_use;
        if (32'(w_n) > WAYS) begin
            w_n = 3'(WAYS);
        end
        for (int i = 0; i < WAYS; i++) begin
            w_use[i] = 32'(i) < 32'(w_n);
        end
    end

    // oldest-way trees: pass 0 all active ways, pass 1 clean ones if prefer_clean
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            for (int k = 0; k < PAD; k++) begin
                w_tree_v[p][k] = 1'b0;
                w_tree_a[p][k] = '0;
                w_tree_i[p][k] = WAY_W'(k);
            end
            for (int k = 0; k < WAYS; k++) begin
                w_tree_a[p][k] = w_row[k*LINE_W + AGE_LSB +: AGE_BITS];
                if (p == 0) begin
                    w_tree_v[p][k] = w_use[k];
                end else begin
                    w_tree_v[p][k] = w_use[k] && !w_row[k*LINE_W] && i_cfg.prefer_clean;
                end
            end
            // right side wins only when strictly older, so ties keep the lower way
            for (int l = 0; l < LVL; l++) begin
                for (int k = 0; k < PAD; k += (2 << l)) begin
                    if (w_tree_v[p][k + (1 << l)] &&
                        (!w_tree_v[p][k] ||
                         (w_tree_a[p][k + (1 << l)] > w_tree_a[p][k]))) begin
                        w_tree_v[p][k] = 1'b1;
                        w_tree_a[p][k] = w_tree_a[p][k + (1 << l)];
                        w_tree_i[p][k] = w_tree_i[p][k + (1 << l)];
                    end
                end
            end
        end
        w_victim = w_tree_v[1][0] ? w_tree_i[1][0] : w_tree_i[0][0];
    end

    always_comb begin
        w_new_row        = w_row;
        w_res.victim_way = '0;
        w_res.victim_valid = 1'b0;
        w_age            = '0;
        case (r_cmd.op)
            OP_ACCESS: begin
                for (int i = 0; i < WAYS; i++) begin
                    if (w_use[i]) begin
                        w_age = w_row[i*LINE_W + AGE_LSB +: AGE_BITS];
                        if (w_age != '1) begin
                            w_age = w_age + 1'b1;
                        end
                        if (w_row[i*LINE_W + TAG_LSB +: TAG_BITS] == w_tag) begin
                            w_age = '0;
                        end
                        w_new_row[i*LINE_W + AGE_LSB +: AGE_BITS] = w_age;
                    end
                end
            end
            OP_VICTIM: begin
                for (int i = 0; i < WAYS; i++) begin
                    if (WAY_W'(i) == w_victim) begin
                        w_new_row[i*LINE_W + AGE_LSB +: AGE_BITS] = '0;
                    end
                end
                w_res.victim_way   = WAY_IN_W'(w_victim);
                w_res.victim_valid = 1'b1;
            end
            OP_RECORD: begin
                for (int i = 0; i < WAYS; i++) begin
                    if (32'(i) == 32'(r_cmd.way_index)) begin
                        w_new_row[i*LINE_W + TAG_LSB +: TAG_BITS] = w_tag;
                        w_new_row[i*LINE_W]                      = r_cmd.modified;
                    end
                end
            end
            default: ;
        endcase
    end

    // result queue
    assign o_empty = (r_ocnt == 2'd0);
    assign o_res   = r_oq[r_orp];
    assign w_opop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_oq[r_owp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_exec) begin
                r_owp <= ~r_owp;
            end
            if (w_opop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(w_exec) - 2'(w_opop);
        end
    end

endmodule

// File: hw/rtl/lru_prefer_clean_victim_select.sv
// top level of the prefer-clean lru victim selector with its register port
//
// items enter through a queue-like port: push an item while full is low.
// kinds: access (age the set, clear the matching way), victim (pick the
// oldest way, clean ways first when prefer_clean is set), record (store a
// way's tag and modified flag). every item yields one result transaction.
// results leave through a queue-like port: while empty is low the oldest
// result is on o_victim_way / o_victim_valid, pop takes it.
// in the back end the set row is read from the metadata ram when an item is
// taken and written back in the cycle after; no new item is taken before
// that write-back. a result enters the result queue with the write-back and
// can be popped from then on, while empty is low.
// after reset the metadata ram is cleared one set per cycle with full held
// high; register writes are taken during that time.
// when pop stays low the two-entry result queue fills, the back end stops,
// then the two-entry command queue fills and full rises. nothing is lost.
// registers: prefer_clean at 0x0, ways_in_use at 0x4; write only when idle.
module lru_prefer_clean_victim_select
    import lpcv_pkg::*;
#(
    parameter int SETS     = 64,
    parameter int WAYS     = 4,
    parameter int TAG_BITS = 20,
    parameter int AGE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SET_IN_W-1:0] i_set_index,
    input  logic [WAY_IN_W-1:0] i_way_index,
    input  logic [TAG_IN_W-1:0] i_tag,
    input  logic                i_modified,
    output logic                empty,
    input  logic                pop,
    output logic [WAY_IN_W-1:0] o_victim_way,
    output logic                o_victim_valid,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    t_cfg r_cfg;
    logic w_wr;
    logic w_open;
    logic w_cmd_valid, w_cmd_pop;
    t_cmd w_cmd;
    t_res w_res;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prefer_clean <= 1'b0;
            r_cfg.ways_in_use  <= WAYS_IN_USE_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_PREFER_CLEAN: r_cfg.prefer_clean <= pwdata[0];
                REG_WAYS_IN_USE:  r_cfg.ways_in_use  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PREFER_CLEAN: prdata = {{(PDATA_W-1){1'b0}}, r_cfg.prefer_clean};
            REG_WAYS_IN_USE:  prdata = {{(PDATA_W-3){1'b0}}, r_cfg.ways_in_use};
            default:          prdata = '0;
        endcase
    end

    lpcv_front #(
        .WAYS(WAYS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_kind     (i_kind),
        .i_set_index(i_set_index),
        .i_way_index(i_way_index),
        .i_tag      (i_tag),
        .i_modified (i_modified),
        .i_open     (w_open),
        .o_cmd_valid(w_cmd_valid),
        .o_cmd      (w_cmd),
        .i_cmd_pop  (w_cmd_pop)
    );

    lpcv_back #(
        .SETS    (SETS),
        .WAYS    (WAYS),
        .TAG_BITS(TAG_BITS),
        .AGE_BITS(AGE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .o_open     (w_open),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .o_empty    (empty),
        .o_res      (w_res),
        .i_pop      (pop)
    );

    assign o_victim_way   = w_res.victim_way;
    assign o_victim_valid = w_res.victim_valid;

endmodule

// File: tb/sv/lpcv_victim_checker.sv
`timescale 1ns / 1ps
// checker for the prefer-clean lru victim selector: tracks set metadata, predicts and compares results
module lpcv_victim_checker
    import lpcv_pkg::*;
#(
    parameter int SETS     = 64,
    parameter int WAYS     = 4,
    parameter int TAG_BITS = 20,
    parameter int AGE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_full,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SET_IN_W-1:0] i_set_index,
    input  logic [WAY_IN_W-1:0] i_way_index,
    input  logic [TAG_IN_W-1:0] i_tag,
    input  logic                i_modified,
    input  logic                i_empty,
    input  logic                i_pop,
    input  logic [WAY_IN_W-1:0] i_victim_way,
    input  logic                i_victim_valid,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [PADDR_W-1:0]  i_paddr,
    input  logic [PDATA_W-1:0]  i_pwdata,
    input  logic                i_pready,
    output int                  o_mismatches,
    output int                  o_outstanding
);

    localparam int LINES = SETS * WAYS;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic [AGE_BITS-1:0] line_age [LINES];
    logic [TAG_BITS-1:0] line_tag [LINES];
    logic                line_dirty [LINES];
    logic                cfg_prefer_clean;
    logic [2:0]          cfg_ways_in_use;

    t_res victim_expect_q [$];
    int   mismatch_count = 0;
    int   outstanding_count = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = outstanding_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t victim checker: %s", $time, what);
    endtask

    // zero means one way, anything above the array size means all of them
    function automatic int active_ways();
        int n;
        n = int'(cfg_ways_in_use);
        if (n == 0) begin
            n = 1;
        end
        if (n > WAYS) begin
            n = WAYS;
        end
        return n;
    endfunction

    function automatic int oldest_way(input int base, input int n, input logic clean_only);
        int                  best;
        int                  i;
        logic                found;
        logic [AGE_BITS-1:0] best_age;
        best     = 0;
        found    = 1'b0;
        best_age = '0;
        for (i = 0; i < n; i++) begin
            if (!(clean_only && line_dirty[base + i]) &&
                    (!found || line_age[base + i] > best_age)) begin
                found    = 1'b1;
                best     = i;
                best_age = line_age[base + i];
            end
        end
        // every way modified: fall back to plain oldest
        if (!found) begin
            for (i = 0; i < n; i++) begin
                if (!found || line_age[base + i] > best_age) begin
                    found    = 1'b1;
                    best     = i;
                    best_age = line_age[base + i];
                end
            end
        end
        return best;
    endfunction

    function automatic t_res predict_result(
        input logic [KIND_W-1:0]   kind,
        input logic [SET_IN_W-1:0] set_index,
        input logic [WAY_IN_W-1:0] way_index,
        input logic [TAG_IN_W-1:0] tag,
        input logic                modified
    );
        t_res                r;
        int                  base;
        int                  n;
        int                  v;
        int                  i;
        logic [TAG_BITS-1:0] line_key;
        r        = '0;
        base     = (int'(set_index) % SETS) * WAYS;
        n        = active_ways();
        line_key = tag[TAG_BITS-1:0];
        case (kind)
            KIND_ACCESS: begin
                for (i = 0; i < n; i++) begin
                    if (line_age[base + i] != AGE_MAX) begin
                        line_age[base + i] = line_age[base + i] + 1'b1;
                    end
                    if (line_tag[base + i] == line_key) begin
                        line_age[base + i] = '0;
                    end
                end
            end
            KIND_VICTIM: begin
                v = oldest_way(base, n, cfg_prefer_clean);
                line_age[base + v] = '0;
                r.victim_way   = WAY_IN_W'(v);
                r.victim_valid = 1'b1;
            end
            KIND_RECORD: begin
                if (int'(way_index) < WAYS) begin
                    line_tag[base + int'(way_index)]   = line_key;
                    line_dirty[base + int'(way_index)] = modified;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res predicted;
        if (!i_rst_n) begin
            foreach (line_age[i]) begin
                line_age[i]   = '0;
                line_tag[i]   = '0;
                line_dirty[i] = 1'b0;
            end
            cfg_prefer_clean = 1'b0;
            cfg_ways_in_use  = WAYS_IN_USE_RESET;
            victim_expect_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_PREFER_CLEAN) begin
                    cfg_prefer_clean = i_pwdata[0];
                end else begin
                    cfg_ways_in_use = i_pwdata[2:0];
                end
            end
            if (i_push && !i_full) begin
                victim_expect_q.push_back(predict_result(i_kind, i_set_index, i_way_index,
                                                         i_tag, i_modified));
            end
            if (i_pop && !i_empty) begin
                if (victim_expect_q.size() == 0) begin
                    report_mismatch($sformatf("result with no item waiting: way %0d valid %0b",
                                              i_victim_way, i_victim_valid));
                end else begin
                    predicted = victim_expect_q.pop_front();
                    if (i_victim_way !== predicted.victim_way) begin
                        report_mismatch($sformatf("victim_way %0d, predicted %0d",
                                                  i_victim_way, predicted.victim_way));
                    end
                    if (i_victim_valid !== predicted.victim_valid) begin
                        report_mismatch($sformatf("victim_valid %0b, predicted %0b",
                                                  i_victim_valid, predicted.victim_valid));
                    end
                end
            end
        end
        outstanding_count = victim_expect_q.size();
    end

endmodule

// File: tb/sv/tb_lru_prefer_clean_victim_select.sv
`timescale 1ns / 1ps
// testbench top of the prefer-clean lru victim selector: stimulus, register setup and verdict
module tb_lru_prefer_clean_victim_select;
    import lpcv_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 140;
    // keeps aging one set so way 0 ends up clearly older than way 1
    localparam int SAT_ACCESSES  = 24;
    localparam logic [7:0]  PHASE_PREFER = 8'b1010_1101;
    localparam logic [23:0] PHASE_WAYS   = {3'd4, 3'd7, 3'd5, 3'd0, 3'd3, 3'd2, 3'd1, 3'd4};
    localparam logic [4*SET_IN_W-1:0] HOT_SETS = {6'd63, 6'd42, 6'd21, 6'd0};

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [KIND_W-1:0]   i_kind = '0;
    logic [SET_IN_W-1:0] i_set_index = '0;
    logic [WAY_IN_W-1:0] i_way_index = '0;
    logic [TAG_IN_W-1:0] i_tag = '0;
    logic                i_modified = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic [WAY_IN_W-1:0] o_victim_way;
    logic                o_victim_valid;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatches;
    int outstanding;
    logic [TAG_IN_W-1:0] tag_pool [8];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lru_prefer_clean_victim_select DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_kind        (i_kind),
        .i_set_index   (i_set_index),
        .i_way_index   (i_way_index),
        .i_tag         (i_tag),
        .i_modified    (i_modified),
        .empty         (empty),
        .pop           (pop),
        .o_victim_way  (o_victim_way),
        .o_victim_valid(o_victim_valid),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    lpcv_victim_checker u_victim_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_kind        (i_kind),
        .i_set_index   (i_set_index),
        .i_way_index   (i_way_index),
        .i_tag         (i_tag),
        .i_modified    (i_modified),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_victim_way  (o_victim_way),
        .i_victim_valid(o_victim_valid),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // push stays high across back-to-back transactions, it only drops on a gap
    task automatic push_item(
        input logic [KIND_W-1:0]   kind,
        input logic [SET_IN_W-1:0] set_index,
        input logic [WAY_IN_W-1:0] way_index,
        input logic [TAG_IN_W-1:0] tag,
        input logic                modified
    );
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_kind      <= kind;
        i_set_index <= set_index;
        i_way_index <= way_index;
        i_tag       <= tag;
        i_modified  <= modified;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic prefer_clean, input logic [2:0] ways_in_use);
        drain_results();
        write_reg(REG_PREFER_CLEAN, PDATA_W'(prefer_clean));
        write_reg(REG_WAYS_IN_USE, PDATA_W'(ways_in_use));
    endtask

    // mostly hot sets and a small tag pool so accesses hit and victims compete
    task automatic random_item();
        int                  pick;
        logic [KIND_W-1:0]   kind;
        logic [SET_IN_W-1:0] set_index;
        logic [TAG_IN_W-1:0] tag;
        pick = $urandom_range(99);
        if (pick < 45) begin
            kind = KIND_ACCESS;
        end else if (pick < 70) begin
            kind = KIND_VICTIM;
        end else if (pick < 96) begin
            kind = KIND_RECORD;
        end else begin
            kind = KIND_UNUSED;
        end
        if ($urandom_range(9) < 8) begin
            set_index = HOT_SETS[$urandom_range(3) * SET_IN_W +: SET_IN_W];
        end else begin
            set_index = SET_IN_W'($urandom_range(63));
        end
        if ($urandom_range(3) != 0) begin
            tag = tag_pool[$urandom_range(7)];
        end else begin
            tag = TAG_IN_W'($urandom);
        end
        push_item(kind, set_index, WAY_IN_W'($urandom_range(3)), tag,
                  1'($urandom_range(1)));
    endtask

    initial begin
        int p;
        int i;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = 20'h5A5A5;
        tag_pool[3] = 20'hA5A5A;
        for (i = 4; i < 8; i++) begin
            tag_pool[i] = TAG_IN_W'($urandom);
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(1'b1, 3'd4);
        push_item(KIND_RECORD, 6'd0, 2'd0, 20'hFFFFF, 1'b1);
        push_item(KIND_RECORD, 6'd0, 2'd1, 20'h00001, 1'b1);
        push_item(KIND_RECORD, 6'd0, 2'd2, 20'h12345, 1'b0);
        push_item(KIND_RECORD, 6'd0, 2'd3, 20'h12345, 1'b0);
        push_item(KIND_ACCESS, 6'd0, 2'd0, 20'h00000, 1'b0);
        // two ways hold the same tag, both get cleared
        push_item(KIND_ACCESS, 6'd0, 2'd0, 20'h12345, 1'b0);
        push_item(KIND_VICTIM, 6'd0, 2'd0, 20'h00000, 1'b0);
        push_item(KIND_VICTIM, 6'd0, 2'd3, 20'hFFFFF, 1'b1);
        push_item(KIND_RECORD, 6'd0, 2'd2, 20'h12345, 1'b1);
        push_item(KIND_RECORD, 6'd0, 2'd3, 20'h12345, 1'b1);
        // whole set modified: falls back to plain oldest
        push_item(KIND_VICTIM, 6'd0, 2'd0, 20'h00000, 1'b0);
        push_item(KIND_UNUSED, 6'd63, 2'd3, 20'hFFFFF, 1'b1);
        push_item(KIND_RECORD, 6'd63, 2'd3, 20'hFFFFF, 1'b1);
        push_item(KIND_ACCESS, 6'd63, 2'd0, 20'hFFFFF, 1'b0);
        push_item(KIND_VICTIM, 6'd63, 2'd0, 20'h00000, 1'b0);
        push_item(KIND_ACCESS, 6'd63, 2'd0, 20'h00000, 1'b0);
        // dirty way 3 is oldest but a clean way wins
        push_item(KIND_VICTIM, 6'd63, 2'd0, 20'h00000, 1'b0);
        push_item(KIND_ACCESS, 6'd0, 2'd0, 20'hFFFFF, 1'b0);
        push_item(KIND_VICTIM, 6'd0, 2'd0, 20'h00000, 1'b0);

        // long run of accesses on one set, no idling so it runs at full rate
        configure(1'b0, 3'd4);
        for (i = 0; i < 4; i++) begin
            push_item(KIND_RECORD, 6'd47, WAY_IN_W'(i), TAG_IN_W'(20'h11111 * (i + 1)), 1'b0);
        end
        for (i = 0; i < 10; i++) begin
            push_item(KIND_ACCESS, 6'd47, 2'd0, 20'hABCDE, 1'b0);
        end
        push_item(KIND_ACCESS, 6'd47, 2'd0, 20'h22222, 1'b0);
        for (i = 0; i < SAT_ACCESSES; i++) begin
            push_item(KIND_ACCESS, 6'd47, 2'd0, 20'hABCDE, 1'b0);
        end
        push_item(KIND_VICTIM, 6'd47, 2'd0, 20'h00000, 1'b0);
        push_item(KIND_VICTIM, 6'd47, 2'd0, 20'h00000, 1'b0);

        for (p = 0; p < 8; p++) begin
            configure(PHASE_PREFER[p], PHASE_WAYS[p * 3 +: 3]);
            case (p % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 65;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 65;
                end
                default: begin
                    sender_idle_pct    = 38;
                    receiver_stall_pct = 38;
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                random_item();
            end
        end

        drain_results();
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_lru_prefer_clean_victim_select: done, clean");
        end else begin
            $display("tb_lru_prefer_clean_victim_select: done, errors");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("tb_lru_prefer_clean_victim_select: done, errors");
        $finish;
    end

endmodule
